// ----- hw/rtl/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the particle pool: command and status
// structs between the controller and the datapath, and the function codes.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int SLOT_MAX = 32;
    localparam int W_Q      = 24;
    localparam int W_SLOT   = 5;
    localparam int W_CNT    = 6;
    localparam int W_AGE    = 24;
    localparam int W_EL     = 16;
    localparam int W_SIZE   = 16;
    localparam int W_GRAV   = 23;

    localparam logic [1:0] FUNC_SPAWN = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_READ,
        OP_MUL_X,
        OP_ADD_X,
        OP_MUL_Y,
        OP_ADD_Y,
        OP_MUL_Z,
        OP_ADD_Z,
        OP_MUL_G,
        OP_ADD_G,
        OP_MUL_S,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_TICK_START,
        OP_TICK_WB,
        OP_SPAWN_WB,
        OP_CLEAR,
        OP_OUT_REC,
        OP_OUT_SPAWN,
        OP_OUT_EMPTY
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic [W_SLOT-1:0]   idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0]          func;
        logic                idx_active;
        logic                any_after;
        logic                any_active;
        logic                out_free;
        logic [W_SLOT-1:0]   last_spawned;
    } t_dp_status;

endpackage

// ----- hw/rtl/pps_ctrl.sv -----
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer of the particle pool: slot search, per-slot tick steps and the
// emit walk. Drives at most one datapath op per cycle.
// ----------------------------------------------------------------------------
module pps_ctrl #(
    parameter int NSLOT = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  pps_pkg::t_dp_status i_status,
    output pps_pkg::t_dp_cmd    o_cmd
);
    import pps_pkg::*;

    localparam logic [W_SLOT-1:0] LAST_IDX = W_SLOT'(NSLOT - 1);
    localparam logic [W_SLOT-1:0] DIV_LAST = W_SLOT'(W_SIZE - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_FIN, S_SRCH, S_SP_WB, S_SP_OUT,
        S_T_CHK, S_T_RD, S_T_MX, S_T_AX, S_T_MY, S_T_AY, S_T_MZ, S_T_AZ,
        S_T_MG, S_T_AG, S_T_MS, S_T_DI, S_T_DV, S_T_WB,
        S_E_START, S_E_CHK, S_E_RD, S_E_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [W_SLOT-1:0]   r_idx, n_idx;
    logic [W_SLOT-1:0]   r_cnt, n_cnt;
    t_dp_op              op;

    function automatic logic [W_SLOT-1:0] wrap_inc(input logic [W_SLOT-1:0] v);
        return (v == LAST_IDX) ? '0 : v + 1'b1;
    endfunction

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        op      = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    op      = OP_CAPTURE;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_status.func)
                    FUNC_SPAWN: begin
                        n_idx   = wrap_inc(i_status.last_spawned);
                        n_cnt   = '0;
                        n_state = S_SRCH;
                    end
                    FUNC_TICK: begin
                        op      = OP_TICK_START;
                        n_idx   = '0;
                        n_state = S_T_CHK;
                    end
                    FUNC_CLEAR: begin
                        op      = OP_CLEAR;
                        n_state = S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    op      = OP_OUT_EMPTY;
                    n_state = S_IDLE;
                end
            end
            S_SRCH: begin
                if (!i_status.idx_active) begin
                    n_state = S_SP_WB;
                end else if (r_cnt == LAST_IDX) begin
                    n_state = S_FIN;    // pool full
                end else begin
                    n_idx = wrap_inc(r_idx);
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SP_WB: begin
                op      = OP_SPAWN_WB;
                n_state = S_SP_OUT;
            end
            S_SP_OUT: begin
                if (i_status.out_free) begin
                    op      = OP_OUT_SPAWN;
                    n_state = S_IDLE;
                end
            end
            S_T_CHK: begin
                if (i_status.idx_active) begin
                    n_state = S_T_RD;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_E_START;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_T_RD: begin op = OP_READ;  n_state = S_T_MX; end
            S_T_MX: begin op = OP_MUL_X; n_state = S_T_AX; end
            S_T_AX: begin op = OP_ADD_X; n_state = S_T_MY; end
            S_T_MY: begin op = OP_MUL_Y; n_state = S_T_AY; end
            S_T_AY: begin op = OP_ADD_Y; n_state = S_T_MZ; end
            S_T_MZ: begin op = OP_MUL_Z; n_state = S_T_AZ; end
            S_T_AZ: begin op = OP_ADD_Z; n_state = S_T_MG; end
            S_T_MG: begin op = OP_MUL_G; n_state = S_T_AG; end
            S_T_AG: begin op = OP_ADD_G; n_state = S_T_MS; end
            S_T_MS: begin op = OP_MUL_S; n_state = S_T_DI; end
            S_T_DI: begin
                op      = OP_DIV_INIT;
                n_cnt   = '0;
                n_state = S_T_DV;
            end
            S_T_DV: begin
                op    = OP_DIV_STEP;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_T_WB;
                end
            end
            S_T_WB: begin
                op = OP_TICK_WB;
                if (r_idx == LAST_IDX) begin
                    n_state = S_E_START;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_T_CHK;
                end
            end
            S_E_START: begin
                if (i_status.any_active) begin
                    n_idx   = '0;
                    n_state = S_E_CHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_E_CHK: begin
                if (i_status.idx_active) begin
                    n_state = S_E_RD;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_E_RD: begin
                op      = OP_READ;
                n_state = S_E_OUT;
            end
            S_E_OUT: begin
                if (i_status.out_free) begin
                    op = OP_OUT_REC;
                    if (!i_status.any_after) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_E_CHK;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
        end
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_cmd.op  = op;
    assign o_cmd.idx = r_idx;

endmodule

// ----- hw/rtl/pps_dp.sv -----
// ----------------------------------------------------------------------------
// pps_dp
// Datapath of the particle pool: slot stores, shared multiplier, bit-serial
// size divider, active bits and the output register.
// ----------------------------------------------------------------------------
module pps_dp #(
    parameter int NSLOT = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pps_pkg::t_dp_cmd                i_cmd,
    output pps_pkg::t_dp_status             o_status,
    input  logic [pps_pkg::W_AGE-1:0]       i_lifetime,
    input  logic [pps_pkg::W_GRAV-1:0]      i_gravity,
    input  logic [pps_pkg::W_SIZE-1:0]      i_max_size,
    input  logic [1:0]                      i_func,
    input  logic signed [pps_pkg::W_Q-1:0]  i_pos_x,
    input  logic signed [pps_pkg::W_Q-1:0]  i_pos_y,
    input  logic signed [pps_pkg::W_Q-1:0]  i_pos_z,
    input  logic signed [pps_pkg::W_Q-1:0]  i_force_x,
    input  logic signed [pps_pkg::W_Q-1:0]  i_force_y,
    input  logic signed [pps_pkg::W_Q-1:0]  i_force_z,
    input  logic [pps_pkg::W_EL-1:0]        i_elapsed,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pps_pkg::W_SLOT-1:0]      o_slot,
    output logic                            o_accepted,
    output logic                            o_valid_res,
    output logic signed [pps_pkg::W_Q-1:0]  o_out_x,
    output logic signed [pps_pkg::W_Q-1:0]  o_out_y,
    output logic signed [pps_pkg::W_Q-1:0]  o_out_z,
    output logic [pps_pkg::W_SIZE-1:0]      o_out_size,
    output logic [pps_pkg::W_CNT-1:0]       o_live_total,
    output logic                            o_last
);
    import pps_pkg::*;

    localparam logic signed [W_Q+2:0] Q_MAX = 27'sd8388607;
    localparam logic signed [W_Q+2:0] Q_MIN = -27'sd8388608;

    function automatic logic signed [W_Q-1:0] sat_q(input logic signed [W_Q+2:0] v);
        if (v > Q_MAX) return Q_MAX[W_Q-1:0];
        if (v < Q_MIN) return Q_MIN[W_Q-1:0];
        return v[W_Q-1:0];
    endfunction

    // captured request
    logic [1:0]             r_func;
    logic signed [W_Q-1:0]  r_in_px, r_in_py, r_in_pz, r_in_vx, r_in_vy, r_in_vz;
    logic [W_EL-1:0]        r_el;

    // slot stores
    logic signed [W_Q-1:0]  mem_px [SLOT_MAX];
    logic signed [W_Q-1:0]  mem_py [SLOT_MAX];
    logic signed [W_Q-1:0]  mem_pz [SLOT_MAX];
    logic signed [W_Q-1:0]  mem_vx [SLOT_MAX];
    logic signed [W_Q-1:0]  mem_vy [SLOT_MAX];
    logic signed [W_Q-1:0]  mem_vz [SLOT_MAX];
    logic [W_AGE-1:0]       mem_age [SLOT_MAX];
    logic [W_SIZE-1:0]      mem_size [SLOT_MAX];

    // read data
    logic signed [W_Q-1:0]  r_px, r_py, r_pz, r_vx, r_vy, r_vz;
    logic [W_AGE-1:0]       r_age;
    logic [W_SIZE-1:0]      r_size;

    // work registers
    logic signed [41:0]     r_prod;
    logic signed [W_Q-1:0]  r_nx, r_ny, r_nz, r_nvy;
    logic [W_AGE-1:0]       r_nage;
    logic [W_AGE-1:0]       r_rem;
    logic [W_SIZE-1:0]      r_nlo, r_quot;

    // pool state
    logic [SLOT_MAX-1:0]    r_active;
    logic [W_CNT-1:0]       r_live;
    logic [W_SLOT-1:0]      r_last_sp;

    // output register
    logic                   r_out_valid;
    logic [W_SLOT-1:0]      r_o_slot;
    logic                   r_o_acc, r_o_vres, r_o_last;
    logic signed [W_Q-1:0]  r_o_x, r_o_y, r_o_z;
    logic [W_SIZE-1:0]      r_o_size;
    logic [W_CNT-1:0]       r_o_live;

    logic signed [24:0]     mul_a;
    logic signed [16:0]     mul_b;
    logic signed [41:0]     mul_p;
    logic                   age_over;
    logic signed [25:0]     delta;
    logic signed [W_Q+2:0]  sum_p;
    logic [W_AGE:0]         age_sum;
    logic [W_AGE:0]         trial;
    logic signed [W_Q-1:0]  sel_pos;
    logic                   any_after;
    logic                   out_free;
    logic                   load_out;
    logic [W_SLOT-1:0]      idx;

    assign idx      = i_cmd.idx;
    assign age_over = (r_age >= i_lifetime);
    assign delta    = r_prod[41:16];
    assign age_sum  = {1'b0, r_age} + {{(W_AGE+1-W_EL){1'b0}}, r_el};
    assign trial    = {r_rem, r_nlo[W_SIZE-1]};

    // shared multiplier operand select
    always_comb begin
        mul_a   = '0;
        mul_b   = {1'b0, r_el};
        sel_pos = r_px;
        case (i_cmd.op)
            OP_MUL_X: mul_a = {r_vx[W_Q-1], r_vx};
            OP_MUL_Y: mul_a = {r_vy[W_Q-1], r_vy};
            OP_MUL_Z: mul_a = {r_vz[W_Q-1], r_vz};
            OP_MUL_G: mul_a = {2'b00, i_gravity};
            OP_MUL_S: begin
                mul_a = age_over ? '0 : {1'b0, i_lifetime - r_age};
                mul_b = {1'b0, i_max_size};
            end
            default: mul_a = '0;
        endcase
        case (i_cmd.op)
            OP_ADD_Y: sel_pos = r_py;
            OP_ADD_Z: sel_pos = r_pz;
            default:  sel_pos = r_px;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // position + floor(force * elapsed / 2^16), or force_y - gravity term
    always_comb begin
        if (i_cmd.op == OP_ADD_G) begin
            sum_p = {{3{r_vy[W_Q-1]}}, r_vy} - {delta[25], delta};
        end else begin
            sum_p = {{3{sel_pos[W_Q-1]}}, sel_pos} + {delta[25], delta};
        end
    end

    always_comb begin
        any_after = 1'b0;
        for (int i = 0; i < SLOT_MAX; i++) begin
            if (r_active[i] && (W_SLOT'(i) > idx)) any_after = 1'b1;
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign load_out = (i_cmd.op == OP_OUT_REC) || (i_cmd.op == OP_OUT_SPAWN)
                   || (i_cmd.op == OP_OUT_EMPTY);

    // payload and stores
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_func  <= i_func;
                r_in_px <= i_pos_x;
                r_in_py <= i_pos_y;
                r_in_pz <= i_pos_z;
                r_in_vx <= i_force_x;
                r_in_vy <= i_force_y;
                r_in_vz <= i_force_z;
                r_el    <= i_elapsed;
            end
            OP_READ: begin
                r_px   <= mem_px[idx];
                r_py   <= mem_py[idx];
                r_pz   <= mem_pz[idx];
                r_vx   <= mem_vx[idx];
                r_vy   <= mem_vy[idx];
                r_vz   <= mem_vz[idx];
                r_age  <= mem_age[idx];
                r_size <= mem_size[idx];
            end
            OP_MUL_X, OP_MUL_Y, OP_MUL_Z, OP_MUL_G, OP_MUL_S: r_prod <= mul_p;
            OP_ADD_X: r_nx <= sat_q(sum_p);
            OP_ADD_Y: r_ny <= sat_q(sum_p);
            OP_ADD_Z: r_nz <= sat_q(sum_p);
            OP_ADD_G: begin
                r_nvy  <= sat_q(sum_p);
                r_nage <= age_sum[W_AGE] ? '1 : age_sum[W_AGE-1:0];
            end
            OP_DIV_INIT: begin
                r_rem  <= r_prod[39:16];
                r_nlo  <= r_prod[15:0];
                r_quot <= '0;
            end
            OP_DIV_STEP: begin
                if (trial >= {1'b0, i_lifetime}) begin
                    r_rem  <= W_AGE'(trial - {1'b0, i_lifetime});
                    r_quot <= {r_quot[W_SIZE-2:0], 1'b1};
                end else begin
                    r_rem  <= trial[W_AGE-1:0];
                    r_quot <= {r_quot[W_SIZE-2:0], 1'b0};
                end
                r_nlo <= {r_nlo[W_SIZE-2:0], 1'b0};
            end
            OP_TICK_WB: begin
                mem_px[idx]   <= r_nx;
                mem_py[idx]   <= r_ny;
                mem_pz[idx]   <= r_nz;
                mem_vy[idx]   <= r_nvy;
                mem_age[idx]  <= r_nage;
                mem_size[idx] <= age_over ? '0 : r_quot;
            end
            OP_SPAWN_WB: begin
                mem_px[idx]   <= r_in_px;
                mem_py[idx]   <= r_in_py;
                mem_pz[idx]   <= r_in_pz;
                mem_vx[idx]   <= r_in_vx;
                mem_vy[idx]   <= r_in_vy;
                mem_vz[idx]   <= r_in_vz;
                mem_age[idx]  <= '0;
                mem_size[idx] <= i_max_size;
            end
            default: ;
        endcase

        if (load_out) begin
            r_o_slot <= (i_cmd.op == OP_OUT_EMPTY) ? '0 : idx;
            r_o_acc  <= (i_cmd.op == OP_OUT_SPAWN);
            r_o_vres <= (i_cmd.op == OP_OUT_REC);
            r_o_x    <= (i_cmd.op == OP_OUT_REC) ? r_px : '0;
            r_o_y    <= (i_cmd.op == OP_OUT_REC) ? r_py : '0;
            r_o_z    <= (i_cmd.op == OP_OUT_REC) ? r_pz : '0;
            r_o_size <= (i_cmd.op == OP_OUT_REC) ? r_size : '0;
            r_o_live <= r_live;
            r_o_last <= (i_cmd.op == OP_OUT_REC) ? !any_after : 1'b1;
        end
    end

    // pool control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_live      <= '0;
            r_last_sp   <= W_SLOT'(NSLOT - 1);
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_CLEAR: begin
                    r_active  <= '0;
                    r_live    <= '0;
                    r_last_sp <= W_SLOT'(NSLOT - 1);
                end
                OP_TICK_START: r_live <= '0;
                OP_TICK_WB: begin
                    if (r_nage >= i_lifetime) begin
                        r_active[idx] <= 1'b0;
                    end else begin
                        r_live <= r_live + 1'b1;
                    end
                end
                OP_SPAWN_WB: begin
                    r_active[idx] <= 1'b1;
                    r_live        <= r_live + 1'b1;
                    r_last_sp     <= idx;
                end
                default: ;
            endcase

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.func         = r_func;
    assign o_status.idx_active   = r_active[idx];
    assign o_status.any_after    = any_after;
    assign o_status.any_active   = |r_active;
    assign o_status.out_free     = out_free;
    assign o_status.last_spawned = r_last_sp;

    assign o_valid      = r_out_valid;
    assign o_slot       = r_o_slot;
    assign o_accepted   = r_o_acc;
    assign o_valid_res  = r_o_vres;
    assign o_out_x      = r_o_x;
    assign o_out_y      = r_o_y;
    assign o_out_z      = r_o_z;
    assign o_out_size   = r_o_size;
    assign o_live_total = r_o_live;
    assign o_last       = r_o_last;

endmodule

// ----- hw/rtl/particle_pool_step.sv -----
// ----------------------------------------------------------------------------
// particle_pool_step
// Fixed pool of particle slots advanced by saturating fixed-point Euler
// steps: spawn (next-fit), tick (update and emit survivors), clear.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  request   in         i_valid / o_ready    i_func, i_pos_*, i_force_*, i_elapsed
//  result    out        o_valid / i_ready    o_slot .. o_last (1..32 per request)
//  config    in         psel/penable/pready  paddr, pwdata, prdata (APB)
//
//  Sequencing: one request at a time. Spawn probes up to SLOTS slots. Tick
//  runs an update pass over each live slot (one shared 25x17 multiplier used
//  five times, then a 16-step bit-serial divide for the size), then an emit
//  pass with one record per surviving slot.
//  Reset is synchronous; it empties the pool and loads register defaults.
//  The result register holds the last result while the next request is
//  taken; a stalled result only stalls the step that would reload it.
//
module particle_pool_step #(
    parameter int SLOTS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_func,
    input  logic signed [pps_pkg::W_Q-1:0]  i_pos_x,
    input  logic signed [pps_pkg::W_Q-1:0]  i_pos_y,
    input  logic signed [pps_pkg::W_Q-1:0]  i_pos_z,
    input  logic signed [pps_pkg::W_Q-1:0]  i_force_x,
    input  logic signed [pps_pkg::W_Q-1:0]  i_force_y,
    input  logic signed [pps_pkg::W_Q-1:0]  i_force_z,
    input  logic [pps_pkg::W_EL-1:0]        i_elapsed,
    // result
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pps_pkg::W_SLOT-1:0]      o_slot,
    output logic                            o_accepted,
    output logic                            o_valid_res,
    output logic signed [pps_pkg::W_Q-1:0]  o_out_x,
    output logic signed [pps_pkg::W_Q-1:0]  o_out_y,
    output logic signed [pps_pkg::W_Q-1:0]  o_out_z,
    output logic [pps_pkg::W_SIZE-1:0]      o_out_size,
    output logic [pps_pkg::W_CNT-1:0]       o_live_total,
    output logic                            o_last,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import pps_pkg::*;

    // slot field is 5 bits and a tick emits at most 32 records
    localparam int NSLOT = (SLOTS < 1) ? 1 : ((SLOTS > SLOT_MAX) ? SLOT_MAX : SLOTS);

    localparam logic [1:0] REG_LIFETIME = 2'd0;
    localparam logic [1:0] REG_GRAVITY  = 2'd1;
    localparam logic [1:0] REG_MAX_SIZE = 2'd2;

    logic [W_AGE-1:0]  r_lifetime;
    logic [W_GRAV-1:0] r_gravity;
    logic [W_SIZE-1:0] r_max_size;
    logic              cfg_wr;

    t_dp_cmd           cmd;
    t_dp_status        status;

    // config registers, written in the APB access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= 24'd65536;    // 1.0 s
            r_gravity  <= 23'd40182;    // 9.81
            r_max_size <= 16'd9830;     // 0.15
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LIFETIME: r_lifetime <= pwdata[W_AGE-1:0];
                REG_GRAVITY:  r_gravity  <= pwdata[W_GRAV-1:0];
                REG_MAX_SIZE: r_max_size <= pwdata[W_SIZE-1:0];
                default: ;              // unmapped, ignored
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LIFETIME: prdata = {{(32-W_AGE){1'b0}}, r_lifetime};
            REG_GRAVITY:  prdata = {{(32-W_GRAV){1'b0}}, r_gravity};
            REG_MAX_SIZE: prdata = {{(32-W_SIZE){1'b0}}, r_max_size};
            default:      prdata = '0;
        endcase
    end

    // sequencer
    pps_ctrl #(
        .NSLOT (NSLOT)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // slot stores, arithmetic and result register
    pps_dp #(
        .NSLOT (NSLOT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_lifetime   (r_lifetime),
        .i_gravity    (r_gravity),
        .i_max_size   (r_max_size),
        .i_func       (i_func),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_force_x    (i_force_x),
        .i_force_y    (i_force_y),
        .i_force_z    (i_force_z),
        .i_elapsed    (i_elapsed),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_slot       (o_slot),
        .o_accepted   (o_accepted),
        .o_valid_res  (o_valid_res),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_out_size   (o_out_size),
        .o_live_total (o_live_total),
        .o_last       (o_last)
    );

endmodule

// ----- hw/rtl/pps_checker.sv -----
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks of the particle pool, bound to the top level.
// ----------------------------------------------------------------------------
module pps_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            o_ready,
    input  logic                            o_valid,
    input  logic                            i_ready,
    input  logic [pps_pkg::W_SLOT-1:0]      o_slot,
    input  logic                            o_accepted,
    input  logic                            o_valid_res,
    input  logic signed [pps_pkg::W_Q-1:0]  o_out_x,
    input  logic signed [pps_pkg::W_Q-1:0]  o_out_y,
    input  logic signed [pps_pkg::W_Q-1:0]  o_out_z,
    input  logic [pps_pkg::W_SIZE-1:0]      o_out_size,
    input  logic [pps_pkg::W_CNT-1:0]       o_live_total,
    input  logic                            o_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_slot) && $stable(o_out_x)
            && $stable(o_out_y) && $stable(o_out_z) && $stable(o_out_size)
            && $stable(o_live_total) && $stable(o_last))
        else $error("result changed while stalled");

    // one request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while busy");

    // a successful spawn is a single, non-record result with a live particle
    a_spawn_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |-> o_last && !o_valid_res && (o_live_total != 0))
        else $error("bad spawn result");

    // a record implies a live particle and is never a spawn result
    a_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res |-> !o_accepted && (o_live_total != 0)
            && (o_live_total <= 6'd32))
        else $error("bad particle record");

endmodule

bind particle_pool_step pps_checker u_pps_checker (.*);
